/* design/ttlcc_pkg.sv */
// Package for the track table line crossing counter.
// Holds field widths, stream layouts, operation and register codes and the slot entry type.
// No dependencies.
`default_nettype none

package ttlcc_pkg;

	// Field widths
	localparam int BOX_W      = 12;
	localparam int SLOT_W     = 4;
	localparam int OP_W       = 2;
	localparam int CENTRE_W   = 13;
	localparam int TOL_W      = 8;
	localparam int STAY_W     = 4;
	localparam int LOST_W     = 6;
	localparam int TOTAL_W    = 16;

	// Stream layouts, padded to whole bytes
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	// Configuration port
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Operation codes
	localparam logic [OP_W-1:0] OP_START  = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOST   = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_ORIENTATION = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AREA_LOW    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LINE_POS    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_AREA_HIGH   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STILL_TOL   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STAY_LIMIT  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LOST_LIMIT  = 3'd6;

	// Register reset values
	localparam logic [CENTRE_W-1:0] AREA_LOW_RST  = 13'd0;
	localparam logic [CENTRE_W-1:0] LINE_POS_RST  = 13'd320;
	localparam logic [CENTRE_W-1:0] AREA_HIGH_RST = 13'd640;
	localparam logic [TOL_W-1:0]    STILL_TOL_RST = 8'd1;
	localparam logic [STAY_W-1:0]   STAY_LIM_RST  = 4'd5;
	localparam logic [LOST_W-1:0]   LOST_LIM_RST  = 6'd10;

	// One slot of the track table as kept in memory
	typedef struct packed {
		logic [CENTRE_W-1:0] first_axis;
		logic [CENTRE_W-1:0] prev_x;
		logic [CENTRE_W-1:0] prev_y;
		logic [STAY_W-1:0]   stay_count;
		logic [LOST_W-1:0]   lost_count;
	} entry_t;

endpackage

`default_nettype wire

/* design/ttlcc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the track table; no package dependencies.
`default_nettype none

module ttlcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/track_table_line_crossing_counter.sv */
// Track table line crossing counter, top level.
// Uses ttlcc_pkg and ttlcc_ram.
//
// Usage:
//  - Input stream (s_*): one beat per tracker event. s_tuser carries the operation
//    (start track, tracked box, target lost), s_tdata the slot and the box.
//  - Output stream (m_*): exactly one beat per input beat, in order: closed and
//    crossing flags plus the running negative and positive totals.
//  - Configuration: cfg_wr_en writes cfg_wdata into register cfg_index in the
//    same edge; write only while no beat is in flight.
// Timing:
//  - An item is handled in order: the accept edge reads the slot from the table RAM
//    into its registered read port; the commit edge, held off while an earlier result
//    is still waiting untaken in the output register, evaluates and writes the slot
//    back and loads the output register. The registered RAM read and the
//    read-modify-write interlock on the table mean a new item is accepted only after
//    the previous one has been written back; the result beat is offered once loaded.
//  - A result waiting in the output register does not block the next accept; it
//    blocks only the write-back of the following item until it is taken.
// Reset: the slot active and previous-box flags and both totals clear at once;
//  registers load their defaults; the table RAM needs no clearing pass.
`default_nettype none

module track_table_line_crossing_counter #(
	parameter int TRACK_SLOTS = 16,
	parameter int COORD_BITS  = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Input stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// s_tdata: slot[3:0], box_x[15:4], box_y[27:16], box_w[39:28], box_h[51:40], zero pad
	input  wire logic [ttlcc_pkg::IN_DATA_W-1:0]    s_tdata,
	// s_tuser: op[1:0]
	input  wire logic [ttlcc_pkg::OP_W-1:0]         s_tuser,
	// Output stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// m_tdata: track_closed[0], crossed_negative[1], crossed_positive[2],
	//          negative_total[18:3], positive_total[34:19], zero pad
	output logic      [ttlcc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// Configuration write port
	input  wire logic                               cfg_wr_en,
	input  wire logic [ttlcc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [ttlcc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	import ttlcc_pkg::*;

	localparam int IDX_W   = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
	localparam int CB      = (COORD_BITS < BOX_W) ? COORD_BITS : BOX_W;
	localparam logic [BOX_W-1:0] COORD_MASK = BOX_W'((32'd1 << CB) - 32'd1);
	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Configuration registers
	logic                orient_q;
	logic [CENTRE_W-1:0] area_low_q;
	logic [CENTRE_W-1:0] line_pos_q;
	logic [CENTRE_W-1:0] area_high_q;
	logic [TOL_W-1:0]    still_tol_q;
	logic [STAY_W-1:0]   stay_limit_q;
	logic [LOST_W-1:0]   lost_limit_q;

	// Per-slot flags
	logic [TRACK_SLOTS-1:0] slot_active_q;
	logic [TRACK_SLOTS-1:0] has_prev_q;

	// Stage 1: accepted item while the table read is under way
	logic [OP_W-1:0]     op_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                in_range_s1;
	logic [CENTRE_W-1:0] cx_s1;
	logic [CENTRE_W-1:0] cy_s1;

	state_t              state_q;
	logic                m_tvalid_q;
	logic                closed_q;
	logic                cross_neg_q;
	logic                cross_pos_q;
	logic [TOTAL_W-1:0]  neg_total_q;
	logic [TOTAL_W-1:0]  pos_total_q;

	// Input field unpacking
	logic [SLOT_W-1:0]       in_slot;
	logic [BOX_W-1:0]        in_x, in_y, in_w, in_h;
	logic [IDX_W+SLOT_W-1:0] slot_wide;
	logic [IDX_W-1:0]        in_idx;
	logic [CENTRE_W-1:0]     in_cx, in_cy;
	logic                    accept;
	logic                    commit;

	assign in_slot   = s_tdata[3:0];
	assign in_x      = s_tdata[15:4];
	assign in_y      = s_tdata[27:16];
	assign in_w      = s_tdata[39:28];
	assign in_h      = s_tdata[51:40];
	assign slot_wide = (IDX_W + SLOT_W)'(in_slot);
	assign in_idx    = slot_wide[IDX_W-1:0];

	// Box centres with truncating halving of the size
	assign in_cx = CENTRE_W'(in_x & COORD_MASK) + CENTRE_W'((in_w & COORD_MASK) >> 1);
	assign in_cy = CENTRE_W'(in_y & COORD_MASK) + CENTRE_W'((in_h & COORD_MASK) >> 1);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);

	// Table memory
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;
	entry_t             wr_entry;
	logic               ram_we;

	ttlcc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TRACK_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (wr_entry),
		.re    (accept),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	// Evaluate the item against its slot
	logic                active, has_prev;
	logic [CENTRE_W-1:0] prev_axis;
	logic                in_area;
	logic [CENTRE_W-1:0] dx;
	logic                still;
	logic [STAY_W-1:0]   stay_inc;
	logic [LOST_W-1:0]   lost_inc;
	logic                closed, counts, do_write;
	logic                next_active, next_prev;
	logic                cross_neg, cross_pos;

	always_comb begin
		rd_entry    = entry_t'(ram_rdata);
		active      = slot_active_q[idx_s1];
		has_prev    = has_prev_q[idx_s1];
		prev_axis   = orient_q ? rd_entry.prev_y : rd_entry.prev_x;
		in_area     = (prev_axis > area_low_q) && (prev_axis < area_high_q);
		dx          = (cx_s1 > rd_entry.prev_x) ? (cx_s1 - rd_entry.prev_x)
		                                        : (rd_entry.prev_x - cx_s1);
		still       = (dx <= CENTRE_W'(still_tol_q));
		stay_inc    = (rd_entry.stay_count == '1) ? rd_entry.stay_count
		                                          : rd_entry.stay_count + 1'b1;
		lost_inc    = (rd_entry.lost_count == '1) ? rd_entry.lost_count
		                                          : rd_entry.lost_count + 1'b1;
		wr_entry    = rd_entry;
		closed      = 1'b0;
		counts      = 1'b0;
		do_write    = 1'b0;
		next_active = active;
		next_prev   = has_prev;

		if (in_range_s1) begin
			unique case (op_s1)
				OP_START: begin
					do_write            = 1'b1;
					wr_entry.first_axis = orient_q ? cy_s1 : cx_s1;
					wr_entry.stay_count = '0;
					wr_entry.lost_count = '0;
					next_active         = 1'b1;
					next_prev           = 1'b0;
				end
				OP_UPDATE: begin
					if (active) begin
						do_write = 1'b1;
						if (has_prev) begin
							if (in_area) begin
								wr_entry.stay_count = still ? stay_inc : '0;
								if (still && (stay_inc > stay_limit_q)) begin
									closed = 1'b1;
									counts = 1'b1;
								end
							end else begin
								closed = 1'b1;
								counts = 1'b1;
							end
						end
						if (!closed) begin
							wr_entry.prev_x = cx_s1;
							wr_entry.prev_y = cy_s1;
							next_prev       = 1'b1;
						end
					end
				end
				OP_LOST: begin
					if (active) begin
						do_write            = 1'b1;
						wr_entry.lost_count = lost_inc;
						if (lost_inc > lost_limit_q) begin
							closed = 1'b1;
							counts = has_prev;
						end
					end
				end
				default: begin
				end
			endcase
		end

		// Free the slot on closing
		if (closed) begin
			next_active = 1'b0;
			next_prev   = 1'b0;
		end

		cross_neg = closed && counts && (rd_entry.first_axis > line_pos_q)
		            && (prev_axis < line_pos_q);
		cross_pos = closed && counts && (rd_entry.first_axis < line_pos_q)
		            && (prev_axis > line_pos_q);
	end

	assign ram_we = commit && do_write;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q     <= 1'b0;
			area_low_q   <= AREA_LOW_RST;
			line_pos_q   <= LINE_POS_RST;
			area_high_q  <= AREA_HIGH_RST;
			still_tol_q  <= STILL_TOL_RST;
			stay_limit_q <= STAY_LIM_RST;
			lost_limit_q <= LOST_LIM_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ORIENTATION: orient_q     <= cfg_wdata[0];
				REG_AREA_LOW:    area_low_q   <= cfg_wdata[CENTRE_W-1:0];
				REG_LINE_POS:    line_pos_q   <= cfg_wdata[CENTRE_W-1:0];
				REG_AREA_HIGH:   area_high_q  <= cfg_wdata[CENTRE_W-1:0];
				REG_STILL_TOL:   still_tol_q  <= cfg_wdata[TOL_W-1:0];
				REG_STAY_LIMIT:  stay_limit_q <= cfg_wdata[STAY_W-1:0];
				REG_LOST_LIMIT:  lost_limit_q <= cfg_wdata[LOST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Slot flags, updated on write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_active_q <= '0;
			has_prev_q    <= '0;
		end else if (commit && in_range_s1) begin
			slot_active_q[idx_s1] <= next_active;
			has_prev_q[idx_s1]    <= next_prev;
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= s_tuser;
			idx_s1      <= in_idx;
			in_range_s1 <= (32'(in_slot) < 32'(TRACK_SLOTS));
			cx_s1       <= in_cx;
			cy_s1       <= in_cy;
		end
	end

	// Sequencer, totals and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			neg_total_q <= '0;
			pos_total_q <= '0;
			closed_q    <= 1'b0;
			cross_neg_q <= 1'b0;
			cross_pos_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (m_tvalid_q && m_tready) begin
						m_tvalid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q     <= ST_IDLE;
						m_tvalid_q  <= 1'b1;
						closed_q    <= closed;
						cross_neg_q <= cross_neg;
						cross_pos_q <= cross_pos;
						if (cross_neg && (neg_total_q != '1)) begin
							neg_total_q <= neg_total_q + 1'b1;
						end
						if (cross_pos && (pos_total_q != '1)) begin
							pos_total_q <= pos_total_q + 1'b1;
						end
					end
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, pos_total_q, neg_total_q, cross_pos_q, cross_neg_q, closed_q};

endmodule

`default_nettype wire

/* design/ttlcc_checker.sv */
// Port-level checker for the track table line crossing counter, bound to the top level.
// Uses ttlcc_pkg for port widths.
`default_nettype none

module ttlcc_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [ttlcc_pkg::OUT_DATA_W-1:0]   m_tdata
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// A new result only follows an item under evaluation
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without an accepted item");

	// A crossing is reported only on a closing track, and in one direction
	a_cross_closed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1] || m_tdata[2]) |-> m_tdata[0] && !(m_tdata[1] && m_tdata[2]))
		else $error("crossing flags inconsistent with track close");

endmodule

bind track_table_line_crossing_counter ttlcc_checker u_ttlcc_checker (.*);

`default_nettype wire
